// ===== sv/ate_pkg.sv =====
// ----------------------------------------------------------------------------
// ate_pkg: shared types and constants for the array table engine
// Table size, derived widths, request kinds, status codes and the command
// word broadcast from the controller to the row of storage cells.
// ----------------------------------------------------------------------------
package ate_pkg;

  // table size and derived widths
  localparam int DEPTH = 64;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // cell index
  localparam int CW    = $clog2(DEPTH + 1);                 // entry count
  localparam int XW    = (CW > 7) ? CW : 7;                 // common compare width
  localparam int FW    = (IW > 6) ? IW : 6;                 // index output staging

  // request kinds
  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_SEARCH = 3'd1,
    K_INSERT = 3'd2,
    K_DELETE = 3'd3,
    K_SORT   = 3'd4,
    K_READ   = 3'd5
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // per-cycle cell operation
  typedef enum logic [2:0] {
    C_HOLD,
    C_APPEND,
    C_INSERT,
    C_DELETE,
    C_ROTATE,
    C_SORT
  } cell_op_e;

  // controller to cell command word
  typedef struct packed {
    cell_op_e           op;
    logic signed [31:0] val;
    logic [XW-1:0]      pos;
    logic [CW-1:0]      count;
    logic               phase;
  } cell_cmd_t;

  // controller FSM states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

endpackage

// ===== sv/ate_cell.sv =====
// ----------------------------------------------------------------------------
// ate_cell: one storage cell of the table row
// Holds one entry and takes its next value from itself, its left or right
// neighbour or the command word, as the broadcast operation dictates.
// ----------------------------------------------------------------------------
module ate_cell (
  input  logic                      clk_i,
  input  logic [ate_pkg::IW-1:0]    idx_i,
  input  ate_pkg::cell_cmd_t        cmd_i,
  input  logic signed [31:0]        left_i,
  input  logic signed [31:0]        right_i,
  output logic signed [31:0]        val_o
);
  import ate_pkg::*;

  logic signed [31:0] val_q, val_d;
  logic [XW-1:0]      ix;
  logic [XW-1:0]      cnt;
  logic               low_of_pair;
  logic               high_of_pair;

  assign ix  = XW'(idx_i);
  assign cnt = XW'(cmd_i.count);

  // odd/even transposition pairing for the current phase
  assign low_of_pair  = (idx_i[0] == cmd_i.phase) && ((ix + XW'(1)) < cnt);
  assign high_of_pair = (idx_i[0] != cmd_i.phase) && (ix != '0) && (ix < cnt);

  // next entry value
  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      C_APPEND: begin
        if (ix == cnt) val_d = cmd_i.val;
      end
      C_INSERT: begin
        if (ix > cmd_i.pos)       val_d = left_i;
        else if (ix == cmd_i.pos) val_d = cmd_i.val;
      end
      C_DELETE: begin
        if (ix >= cmd_i.pos) val_d = right_i;
      end
      C_ROTATE: val_d = right_i;
      C_SORT: begin
        if (low_of_pair && (val_q > right_i))      val_d = right_i;
        else if (high_of_pair && (left_i > val_q)) val_d = left_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== sv/ate_ctrl.sv =====
// ----------------------------------------------------------------------------
// ate_ctrl: request sequencer for the array table engine
// Latches a request, drives the cell row for one step or one full pass,
// watches the head cell while the row rotates, and builds the result word.
// ----------------------------------------------------------------------------
module ate_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic [2:0]              kind_i,
  input  logic signed [31:0]      operand_value_i,
  input  logic [6:0]              position_i,
  input  logic signed [31:0]      head_i,
  output ate_pkg::cell_cmd_t      cmd_o,
  output logic                    busy,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [5:0]              found_index_o,
  output logic signed [31:0]      read_value_o,
  output logic [6:0]              entry_count_o
);
  import ate_pkg::*;

  state_e             state_q, state_d;
  logic [2:0]         kind_q;
  logic signed [31:0] val_q;
  logic [6:0]         pos_q;
  logic [IW-1:0]      step_q;
  logic [CW-1:0]      count_q, count_d;
  status_e            status_q, status_d;
  logic [IW-1:0]      fidx_q, fidx_d;
  logic               found_q, found_d;
  logic signed [31:0] rval_q, rval_d;
  logic               accept;
  logic               fin;
  logic [XW-1:0]      ext_pos, ext_cnt, ext_step;
  logic               last, full;
  logic [FW-1:0]      fidx_x;
  logic [XW-1:0]      count_x;

  assign accept   = start && (state_q == S_IDLE);
  assign ext_pos  = XW'(pos_q);
  assign ext_cnt  = XW'(count_q);
  assign ext_step = XW'(step_q);
  assign last     = (step_q == IW'(DEPTH - 1));
  assign full     = (count_q == CW'(DEPTH));

  // step decode: cell command, completion and result updates
  always_comb begin
    cmd_o.op    = C_HOLD;
    cmd_o.val   = val_q;
    cmd_o.pos   = ext_pos;
    cmd_o.count = count_q;
    cmd_o.phase = step_q[0];
    fin         = 1'b0;
    count_d     = count_q;
    status_d    = status_q;
    fidx_d      = fidx_q;
    found_d     = found_q;
    rval_d      = rval_q;
    if (state_q == S_RUN) begin
      case (kind_q)
        K_APPEND: begin
          fin = 1'b1;
          if (full) status_d = ST_FULL;
          else begin
            cmd_o.op = C_APPEND;
            count_d  = count_q + CW'(1);
          end
        end
        K_INSERT: begin
          fin = 1'b1;
          if (full)                   status_d = ST_FULL;
          else if (ext_pos > ext_cnt) status_d = ST_RANGE;
          else begin
            cmd_o.op = C_INSERT;
            count_d  = count_q + CW'(1);
          end
        end
        K_DELETE: begin
          fin = 1'b1;
          if (ext_pos >= ext_cnt) status_d = ST_RANGE;
          else begin
            cmd_o.op = C_DELETE;
            count_d  = count_q - CW'(1);
          end
        end
        K_SEARCH: begin
          cmd_o.op = C_ROTATE;
          fin      = last;
          if (!found_q && (ext_step < ext_cnt) && (head_i == val_q)) begin
            found_d = 1'b1;
            fidx_d  = step_q;
            rval_d  = val_q;
          end
          if (last) status_d = found_d ? ST_OK : ST_NOT_FOUND;
        end
        K_READ: begin
          cmd_o.op = C_ROTATE;
          fin      = last;
          if ((ext_step == ext_pos) && (ext_pos < ext_cnt)) rval_d = head_i;
          if (last) status_d = (ext_pos < ext_cnt) ? ST_OK : ST_RANGE;
        end
        K_SORT: begin
          cmd_o.op = C_SORT;
          fin      = last;
        end
        default: fin = 1'b1;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_RUN;
      S_RUN:   if (fin) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE:  busy = 1'b0;
      S_DONE:  done_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_i;
      val_q    <= operand_value_i;
      pos_q    <= position_i;
      step_q   <= '0;
      status_q <= ST_OK;
      fidx_q   <= '0;
      found_q  <= 1'b0;
      rval_q   <= '0;
    end else if (state_q == S_RUN) begin
      step_q   <= step_q + IW'(1);
      status_q <= status_d;
      fidx_q   <= fidx_d;
      found_q  <= found_d;
      rval_q   <= rval_d;
    end
  end

  // result word
  assign fidx_x        = FW'(fidx_q);
  assign count_x       = XW'(count_q);
  assign status_o      = status_q;
  assign found_index_o = fidx_x[5:0];
  assign read_value_o  = rval_q;
  assign entry_count_o = count_x[6:0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond table size");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> $past(state_q == S_RUN))
    else $error("result word without a run step");

  a_count_only_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_RUN |=> $stable(count_q))
    else $error("count changed outside a run step");

  a_busy_while_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("strobe while idle");
`endif

endmodule

// ===== sv/array_table_engine.sv =====
// ----------------------------------------------------------------------------
// array_table_engine: ordered table of signed 32-bit entries with a count
// Append, search, insert, delete, sort and read requests on a row of cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result word
// follows, shown for a single cycle with done_o, and the receiver cannot
// stall it. Append, insert, delete and the unused kinds finish in their first
// run step; done_o follows in the done state and busy drops after it. Search
// and read rotate the whole cell row once past the head cell, and sort runs
// DEPTH odd/even exchange passes, before done_o and the drop of busy.
module array_table_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] operand_value_i,
  input  logic [6:0]         position_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [5:0]         found_index_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]         entry_count_o
);
  import ate_pkg::*;

  cell_cmd_t          cmd;
  logic signed [31:0] vals [DEPTH];

  // sequencer
  ate_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .kind_i          (kind_i),
    .operand_value_i (operand_value_i),
    .position_i      (position_i),
    .head_i          (vals[0]),
    .cmd_o           (cmd),
    .busy            (busy),
    .done_o          (done_o),
    .status_o        (status_o),
    .found_index_o   (found_index_o),
    .read_value_o    (read_value_o),
    .entry_count_o   (entry_count_o)
  );

  // cell row, closed into a ring for rotation
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    ate_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IW'(k)),
      .cmd_i   (cmd),
      .left_i  (vals[(k + DEPTH - 1) % DEPTH]),
      .right_i (vals[(k + 1) % DEPTH]),
      .val_o   (vals[k])
    );
  end

endmodule
